// File: rtl/core/stt_pkg.sv
package stt_pkg;

  // Field widths of the stream payload.
  localparam int SLOT_W  = 12;
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 16;
  localparam int PLY_W   = 16;
  localparam int RD_W    = 10;
  localparam int KIND_W  = 2;
  localparam int SCORE_W = 32;
  localparam int MOVE_W  = 16;
  localparam int FLAG_W  = 3;
  localparam int RANK_W  = 17;
  localparam int ADJ_W   = 34;

  // Configuration register widths and indexes.
  localparam int MS_W      = 30;
  localparam int MM_W      = 10;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_SCORE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_MARGIN = 1'd1;

  // Stream bus widths.
  localparam int IN_DATA_W  = 232;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 4;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  // Entry flag codes; the low two bits match the request's bound kind.
  localparam logic [FLAG_W-1:0] ENTRY_EXACT  = 3'd0;
  localparam logic [FLAG_W-1:0] ENTRY_STATIC = 3'd1;
  localparam logic [FLAG_W-1:0] ENTRY_ALPHA  = 3'd2;
  localparam logic [FLAG_W-1:0] ENTRY_BETA   = 3'd3;
  localparam logic [FLAG_W-1:0] ENTRY_EMPTY  = 3'd4;

  localparam logic signed [ADJ_W-1:0] SCORE_MAX = 34'sd2147483647;

  // One classified request as it waits between front and back.
  typedef struct packed {
    logic                      is_store;
    logic [SLOT_W-1:0]         slot;
    logic [SLOT_W-1:0]         quot;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic [RANK_W-1:0]         rank;
    logic [PLY_W-1:0]          ply;
    logic [RD_W-1:0]           rd;
    logic [KIND_W-1:0]         kind;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
  } q_item_t;

  // Clamp a widened score to the symmetric 32-bit range.
  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [ADJ_W-1:0] v);
    logic signed [ADJ_W-1:0] c;
    c = v;
    if (v > SCORE_MAX) begin
      c = SCORE_MAX;
    end else if (v < -SCORE_MAX) begin
      c = -SCORE_MAX;
    end
    return c[SCORE_W-1:0];
  endfunction

endpackage

// File: rtl/core/stt_front.sv
module stt_front #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [stt_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic [stt_pkg::IN_USER_W-1:0]         in_tuser,
  input  logic signed [stt_pkg::SCORE_W-1:0]    mate_hi,
  input  logic                                  q_full,
  output logic                                  q_push,
  output stt_pkg::q_item_t                      q_din
);

  // Slot reduction: floor(slot / TABLE_ENTRIES) by an exact reciprocal for 12-bit slots.
  localparam int     AW      = $clog2(TABLE_ENTRIES);
  localparam int     SHIFT   = stt_pkg::SLOT_W + AW;
  localparam longint RECIP   = ((longint'(1) << SHIFT) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
  localparam int     RECIP_W = 15;
  localparam int     PROD_W  = stt_pkg::SLOT_W + RECIP_W;

  logic                                f_valid_r;
  logic [stt_pkg::IN_DATA_W-1:0]       f_data_r;
  logic [stt_pkg::IN_USER_W-1:0]       f_user_r;

  logic [stt_pkg::SLOT_W-1:0]          slot;
  logic [stt_pkg::DEPTH_W-1:0]         depth;
  logic [stt_pkg::PLY_W-1:0]           ply;
  logic [stt_pkg::RD_W-1:0]            rd;
  logic signed [stt_pkg::SCORE_W-1:0]  score;
  logic [PROD_W-1:0]                   prod;
  logic signed [stt_pkg::ADJ_W-1:0]    score_w;
  logic signed [stt_pkg::ADJ_W-1:0]    hi_w;
  logic signed [stt_pkg::ADJ_W-1:0]    lo_w;
  logic signed [stt_pkg::ADJ_W-1:0]    rd_w;
  logic signed [stt_pkg::ADJ_W-1:0]    plus_w;
  logic signed [stt_pkg::ADJ_W-1:0]    minus_w;
  logic signed [stt_pkg::ADJ_W-1:0]    adj_w;
  logic                                up;
  logic                                down;

  // Input register stage; it refills whenever the queue takes its content.
  assign in_tready = !f_valid_r || !q_full;
  assign q_push    = f_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_tready) begin
      f_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      f_data_r <= in_tdata;
      f_user_r <= in_tuser;
    end
  end

  // Field unpacking of the held transaction.
  always_comb begin
    slot  = f_data_r[11:0];
    depth = f_data_r[91:76];
    ply   = f_data_r[107:92];
    rd    = f_data_r[117:108];
    score = f_data_r[149:118];
  end

  // Quotient of the slot index, used by the back to wrap the table address.
  always_comb begin
    prod = PROD_W'(slot) * PROD_W'(RECIP_W'(RECIP));
  end

  // Mate-distance shift on store: outward past the threshold, then the
  // lower test on the already shifted value, then saturation.
  always_comb begin
    score_w = {{(stt_pkg::ADJ_W-stt_pkg::SCORE_W){score[stt_pkg::SCORE_W-1]}}, score};
    hi_w    = {{(stt_pkg::ADJ_W-stt_pkg::SCORE_W){mate_hi[stt_pkg::SCORE_W-1]}}, mate_hi};
    lo_w    = -hi_w;
    rd_w    = {{(stt_pkg::ADJ_W-stt_pkg::RD_W){1'b0}}, rd};
    plus_w  = score_w + rd_w;
    minus_w = score_w - rd_w;
    up      = score_w > hi_w;
    down    = up ? (plus_w < lo_w) : (score_w < lo_w);
    if (up && down) begin
      adj_w = score_w;
    end else if (up) begin
      adj_w = plus_w;
    end else if (down) begin
      adj_w = minus_w;
    end else begin
      adj_w = score_w;
    end
  end

  // Classified queue entry.
  always_comb begin
    q_din          = '0;
    q_din.is_store = (f_user_r[0] == stt_pkg::REQ_STORE);
    q_din.slot     = slot;
    q_din.quot     = stt_pkg::SLOT_W'(prod >> SHIFT);
    q_din.key      = f_data_r[75:12];
    q_din.depth    = depth;
    q_din.rank     = {1'b0, depth} + {1'b0, ply};
    q_din.ply      = ply;
    q_din.rd       = rd;
    q_din.kind     = f_user_r[2:1];
    q_din.score    = stt_pkg::sat_score(adj_w);
    q_din.move     = f_data_r[165:150];
    q_din.alpha    = f_data_r[197:166];
    q_din.beta     = f_data_r[229:198];
  end

endmodule

// File: rtl/core/stt_queue.sv
module stt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stt_pkg::q_item_t din,
  output logic             full,
  input  logic             pop,
  output stt_pkg::q_item_t dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(stt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  stt_pkg::q_item_t   slots_r [stt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full  = (count_r == CNT_W'(stt_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slots_r[rd_ptr_r];

  // Occupancy follows push and pop; both may happen in one cycle.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/core/stt_back.sv
module stt_back #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MOVE_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  stt_pkg::q_item_t                    q_dout,
  output logic                                q_pop,
  input  logic signed [stt_pkg::SCORE_W-1:0]  mate_hi,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stt_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [stt_pkg::OUT_USER_W-1:0]      out_tuser
);

  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int MV_W = (MOVE_BITS < stt_pkg::MOVE_W) ? MOVE_BITS : stt_pkg::MOVE_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // Table storage, one array per entry field.
  logic [stt_pkg::KEY_W-1:0]          mem_key   [TABLE_ENTRIES];
  logic [stt_pkg::DEPTH_W-1:0]        mem_depth [TABLE_ENTRIES];
  logic [stt_pkg::PLY_W-1:0]          mem_ply   [TABLE_ENTRIES];
  logic [stt_pkg::FLAG_W-1:0]         mem_flag  [TABLE_ENTRIES];
  logic [stt_pkg::SCORE_W-1:0]        mem_score [TABLE_ENTRIES];
  logic [MV_W-1:0]                    mem_move  [TABLE_ENTRIES];

  logic [1:0]                         state_r;
  logic [1:0]                         state_nxt;
  logic [AW-1:0]                      clr_cnt_r;
  logic [AW-1:0]                      clr_cnt_nxt;
  stt_pkg::q_item_t                   item_r;
  logic [AW-1:0]                      addr_r;

  logic [stt_pkg::KEY_W-1:0]          rd_key_r;
  logic [stt_pkg::DEPTH_W-1:0]        rd_depth_r;
  logic [stt_pkg::PLY_W-1:0]          rd_ply_r;
  logic [stt_pkg::FLAG_W-1:0]         rd_flag_r;
  logic signed [stt_pkg::SCORE_W-1:0] rd_score_r;
  logic [MV_W-1:0]                    rd_move_r;

  logic                               out_valid_r;
  logic                               out_known_r;
  logic signed [stt_pkg::SCORE_W-1:0] out_score_r;
  logic                               out_hint_r;
  logic [stt_pkg::MOVE_W-1:0]         out_move_r;
  logic                               out_exact_r;
  logic                               out_done_r;

  logic [31:0]                        head_span;
  logic [31:0]                        head_off;
  logic [AW-1:0]                      head_addr;
  logic                               out_free;
  logic                               fire;
  logic                               clearing;
  logic                               clear_last;
  logic [stt_pkg::FLAG_W-1:0]         new_flag;
  logic [stt_pkg::RANK_W-1:0]         old_rank;
  logic                               store_ok;
  logic                               mem_we;
  logic [AW-1:0]                      wr_addr;
  logic                               hit;
  logic                               deep;
  logic signed [stt_pkg::ADJ_W-1:0]   v_w;
  logic signed [stt_pkg::ADJ_W-1:0]   hi_w;
  logic signed [stt_pkg::ADJ_W-1:0]   lo_w;
  logic signed [stt_pkg::ADJ_W-1:0]   rd_w;
  logic signed [stt_pkg::ADJ_W-1:0]   exact_w;
  logic                               known_nxt;
  logic signed [stt_pkg::SCORE_W-1:0] score_nxt;
  logic                               hint_nxt;
  logic [stt_pkg::MOVE_W-1:0]         move_nxt;
  logic                               exact_nxt;
  logic                               done_nxt;

  // Table address of the queue head: slot minus quotient times table size.
  always_comb begin
    head_span = 32'(q_dout.quot) * 32'(TABLE_ENTRIES);
    head_off  = 32'(q_dout.slot) - head_span;
    head_addr = head_off[AW-1:0];
  end

  // Sequencer control.
  always_comb begin
    clearing   = (state_r == ST_CLEAR);
    clear_last = (clr_cnt_r == AW'(TABLE_ENTRIES - 1));
    out_free   = !out_valid_r || out_tready;
    q_pop      = (state_r == ST_IDLE) && !q_empty;
    fire       = (state_r == ST_EXEC) && out_free;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Request held for its execute cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_dout;
      addr_r <= head_addr;
    end
  end

  // Replacement rule for a store.
  always_comb begin
    new_flag = {1'b0, item_r.kind};
    old_rank = {1'b0, rd_depth_r} + {1'b0, rd_ply_r};
    store_ok = 1'b1;
    if (rd_flag_r == stt_pkg::ENTRY_EXACT && new_flag != stt_pkg::ENTRY_EXACT) begin
      store_ok = 1'b0;
    end else if (rd_flag_r != stt_pkg::ENTRY_EMPTY && old_rank > item_r.rank) begin
      store_ok = 1'b0;
    end
    mem_we  = clearing || (fire && item_r.is_store && store_ok);
    wr_addr = clearing ? clr_cnt_r : addr_r;
  end

  // Table write (store or clearing pass) and registered read at the queue head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[wr_addr]   <= clearing ? '0 : item_r.key;
      mem_depth[wr_addr] <= clearing ? '0 : item_r.depth;
      mem_flag[wr_addr]  <= clearing ? stt_pkg::ENTRY_EMPTY : new_flag;
      mem_ply[wr_addr]   <= item_r.ply;
      mem_score[wr_addr] <= item_r.score;
      mem_move[wr_addr]  <= item_r.move[MV_W-1:0];
    end
    if (q_pop) begin
      rd_key_r   <= mem_key[head_addr];
      rd_depth_r <= mem_depth[head_addr];
      rd_ply_r   <= mem_ply[head_addr];
      rd_flag_r  <= mem_flag[head_addr];
      rd_score_r <= mem_score[head_addr];
      rd_move_r  <= mem_move[head_addr];
    end
  end

  // Mate-distance shift removed on an exact lookup.
  always_comb begin
    v_w  = {{(stt_pkg::ADJ_W-stt_pkg::SCORE_W){rd_score_r[stt_pkg::SCORE_W-1]}}, rd_score_r};
    hi_w = {{(stt_pkg::ADJ_W-stt_pkg::SCORE_W){mate_hi[stt_pkg::SCORE_W-1]}}, mate_hi};
    lo_w = -hi_w;
    rd_w = {{(stt_pkg::ADJ_W-stt_pkg::RD_W){1'b0}}, item_r.rd};
    if (v_w > hi_w) begin
      exact_w = v_w - rd_w;
    end else if (v_w < lo_w) begin
      exact_w = v_w + rd_w;
    end else begin
      exact_w = v_w;
    end
  end

  // Result of the transaction in execute.
  always_comb begin
    hit       = (rd_key_r == item_r.key) && (rd_flag_r != stt_pkg::ENTRY_EMPTY);
    deep      = (rd_depth_r >= item_r.depth);
    known_nxt = 1'b0;
    score_nxt = '0;
    hint_nxt  = 1'b0;
    move_nxt  = '0;
    exact_nxt = 1'b0;
    done_nxt  = 1'b0;
    if (item_r.is_store) begin
      done_nxt = store_ok;
    end else if (hit) begin
      exact_nxt = (rd_flag_r == stt_pkg::ENTRY_EXACT);
      if (deep) begin
        case (rd_flag_r)
          stt_pkg::ENTRY_EXACT: begin
            known_nxt = 1'b1;
            score_nxt = stt_pkg::sat_score(exact_w);
          end
          stt_pkg::ENTRY_STATIC: begin
            known_nxt = 1'b1;
            score_nxt = rd_score_r;
          end
          stt_pkg::ENTRY_ALPHA: begin
            if (rd_score_r <= item_r.alpha) begin
              known_nxt = 1'b1;
              score_nxt = item_r.alpha;
            end
          end
          stt_pkg::ENTRY_BETA: begin
            if (rd_score_r >= item_r.beta) begin
              known_nxt = 1'b1;
              score_nxt = item_r.beta;
            end
          end
          default: begin
            known_nxt = 1'b0;
          end
        endcase
      end
      if (!known_nxt && (rd_flag_r inside {stt_pkg::ENTRY_EXACT, stt_pkg::ENTRY_BETA})) begin
        hint_nxt = 1'b1;
        move_nxt = stt_pkg::MOVE_W'(rd_move_r);
      end
    end
  end

  // Output register; the next request may be read while a result waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_known_r <= known_nxt;
      out_score_r <= score_nxt;
      out_hint_r  <= hint_nxt;
      out_move_r  <= move_nxt;
      out_exact_r <= exact_nxt;
      out_done_r  <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_move_r, out_score_r};
  assign out_tuser  = {out_done_r, out_exact_r, out_hint_r, out_known_r};

  // A popped request enters execute in the following cycle.
  a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_EXEC))
    else $error("popped request did not enter execute");

  // Execution always leaves exactly one pending result and frees the sequencer.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_valid_r && state_r == ST_IDLE))
    else $error("executed request left no result");

  // The clearing pass ends after its last entry.
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (clearing && clear_last) |=> (state_r == ST_IDLE))
    else $error("clearing pass did not finish");

  // A store result carries no lookup information.
  a_store_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (!out_known_r && !out_hint_r && !out_exact_r))
    else $error("store result carries lookup fields");

  // A known score and a move hint are never offered together.
  a_known_hint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_known_r && out_hint_r))
    else $error("score and hint both offered");

endmodule

// File: rtl/core/search_transposition_table.sv
// Direct-mapped transposition table with depth-preferred replacement. Each request
// (lookup or store, in in_tuser) arrives as one input transaction and produces exactly
// one result transaction, in order. After reset the block marks all TABLE_ENTRIES entries
// (4096 by default) empty, one after another; in that time up to three requests are
// taken and held (one in the front register, two in the queue) but none is executed;
// configuration writes are accepted throughout. The front stage registers and classifies
// each request and applies the mate-distance shift to stored scores; a two-entry queue
// separates it from the back, which owns the table memory. The back handles one request
// at a time: it pops it and reads the table, then evaluates it and writes back, and takes
// the next only after that. A request passes the front register, the queue, the back's
// read registers and the output register. Configuration must be written only while no
// request is in flight.
module search_transposition_table #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MOVE_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input tdata, from bit 0: slot_index, position_key, search_depth, game_ply,
  // root_distance, score_in, best_move_in, alpha_bound, beta_bound, zero padding.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [stt_pkg::IN_DATA_W-1:0]     in_tdata,
  // Input tuser, from bit 0: req_type, bound_kind.
  input  logic [stt_pkg::IN_USER_W-1:0]     in_tuser,
  // Output tdata, from bit 0: score_out, hint_move.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [stt_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Output tuser, from bit 0: score_known, hint_valid, entry_exact, store_done.
  output logic [stt_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_we,
  input  logic [stt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stt_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [stt_pkg::MS_W-1:0]           mate_score_r;
  logic [stt_pkg::MM_W-1:0]           mate_margin_r;
  logic signed [stt_pkg::SCORE_W-1:0] mate_hi;
  logic                               q_full;
  logic                               q_push;
  logic                               q_pop;
  logic                               q_empty;
  stt_pkg::q_item_t                   q_din;
  stt_pkg::q_item_t                   q_dout;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_score_r  <= stt_pkg::MS_W'(100000);
      mate_margin_r <= stt_pkg::MM_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        stt_pkg::CFG_MATE_SCORE:  mate_score_r  <= cfg_wdata[stt_pkg::MS_W-1:0];
        stt_pkg::CFG_MATE_MARGIN: mate_margin_r <= cfg_wdata[stt_pkg::MM_W-1:0];
        default: begin
          mate_score_r <= mate_score_r;
        end
      endcase
    end
  end

  // Mate threshold; may be negative when the margin exceeds the mate score.
  assign mate_hi = $signed({2'b00, mate_score_r}) -
                   $signed({{(stt_pkg::SCORE_W-stt_pkg::MM_W){1'b0}}, mate_margin_r});

  stt_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .mate_hi   (mate_hi),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  stt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  stt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MOVE_BITS     (MOVE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .mate_hi    (mate_hi),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/sv/search_transposition_table_test.sv
`timescale 1ns / 100ps

module search_transposition_table_test;

  localparam int SLOTS = 4096;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 250;
  localparam longint SCORE_TOP = 64'sd2147483647;

  // Request and entry codes.
  localparam logic REQ_LOOKUP = stt_pkg::REQ_LOOKUP;
  localparam logic REQ_STORE  = stt_pkg::REQ_STORE;
  localparam logic [2:0] ENTRY_EXACT  = stt_pkg::ENTRY_EXACT;
  localparam logic [2:0] ENTRY_STATIC = stt_pkg::ENTRY_STATIC;
  localparam logic [2:0] ENTRY_ALPHA  = stt_pkg::ENTRY_ALPHA;
  localparam logic [2:0] ENTRY_BETA   = stt_pkg::ENTRY_BETA;
  localparam logic [2:0] ENTRY_EMPTY  = stt_pkg::ENTRY_EMPTY;

  // Bound kinds as they travel in the request.
  localparam logic [1:0] KIND_EXACT  = 2'(ENTRY_EXACT);
  localparam logic [1:0] KIND_STATIC = 2'(ENTRY_STATIC);
  localparam logic [1:0] KIND_ALPHA  = 2'(ENTRY_ALPHA);
  localparam logic [1:0] KIND_BETA   = 2'(ENTRY_BETA);

  // Receiver stall patterns.
  localparam int RX_OPEN    = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_SPARSE  = 3;

  typedef struct packed {
    logic                is_store;
    logic [11:0]         slot;
    logic [63:0]         key;
    logic [15:0]         depth;
    logic [15:0]         ply;
    logic [9:0]          rd;
    logic [1:0]          kind;
    logic signed [31:0]  score;
    logic [15:0]         move;
    logic signed [31:0]  alpha;
    logic signed [31:0]  beta;
  } tt_req_t;

  typedef struct packed {
    logic                known;
    logic signed [31:0]  score;
    logic                hint_valid;
    logic [15:0]         hint;
    logic                exact;
    logic                stored;
  } tt_ans_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [stt_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic [stt_pkg::IN_USER_W-1:0]    in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [stt_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic [stt_pkg::OUT_USER_W-1:0]   out_tuser;
  logic                             cfg_we = 1'b0;
  logic [stt_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [stt_pkg::CFG_W-1:0]        cfg_wdata = '0;

  // Shadow copy of the table and of the mate registers.
  logic [63:0]         tt_key [SLOTS];
  logic [15:0]         tt_depth [SLOTS];
  logic [15:0]         tt_ply [SLOTS];
  logic [2:0]          tt_flag [SLOTS];
  logic signed [31:0]  tt_score [SLOTS];
  logic [15:0]         tt_move [SLOTS];
  longint              ms_q = 100000;
  longint              mm_q = 64;

  tt_req_t   request_q[$];
  tt_ans_t   answer_q[$];
  int        issued = 0;
  int        received = 0;
  int        errors = 0;
  int        cycles = 0;

  // Traffic shaping, set per phase.
  int        tx_gap_max = 0;
  int        rx_mode = RX_OPEN;
  int        hold_tag = 0;
  logic [11:0] hot_base = '0;
  logic [63:0] key_pool [8];

  search_transposition_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // slot, key, depth, ply, rd, score, move, alpha, beta
    .in_tuser   (in_tuser),   // req_type, bound_kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // score_out, hint_move
    .out_tuser  (out_tuser),  // score_known, hint_valid, entry_exact, store_done
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Clamp a wide score to the symmetric 32-bit range.
  function automatic logic signed [31:0] sat_word(input longint v);
    if (v > SCORE_TOP) begin
      return 32'sd2147483647;
    end
    if (v < -SCORE_TOP) begin
      return -32'sd2147483647;
    end
    return v[31:0];
  endfunction

  // Apply one request to the shadow table and work out its answer.
  function automatic tt_ans_t resolve_request(input tt_req_t r);
    tt_ans_t    a;
    longint     hi;
    longint     lo;
    longint     v;
    longint     res;
    logic [2:0] flag;
    logic       known;
    int         ix;
    a = '0;
    hi = ms_q - mm_q;
    lo = -hi;
    ix = int'(r.slot);
    flag = tt_flag[ix];
    known = 1'b0;
    res = 0;
    if (r.is_store == REQ_STORE) begin
      // An exact entry only yields to another exact one, and deeper or newer work wins.
      if (flag == ENTRY_EXACT && r.kind != KIND_EXACT) begin
        return a;
      end
      if (flag != ENTRY_EMPTY &&
          int'(tt_depth[ix]) + int'(tt_ply[ix]) > int'(r.depth) + int'(r.ply)) begin
        return a;
      end
      v = longint'($signed(r.score));
      if (v > hi) begin
        v = v + longint'(r.rd);
      end
      if (v < lo) begin
        v = v - longint'(r.rd);
      end
      tt_key[ix] = r.key;
      tt_depth[ix] = r.depth;
      tt_ply[ix] = r.ply;
      tt_flag[ix] = {1'b0, r.kind};
      tt_score[ix] = sat_word(v);
      tt_move[ix] = r.move;
      a.stored = 1'b1;
      return a;
    end
    if (tt_key[ix] != r.key || flag == ENTRY_EMPTY) begin
      return a;
    end
    v = longint'(tt_score[ix]);
    a.exact = (flag == ENTRY_EXACT);
    if (tt_depth[ix] >= r.depth) begin
      if (flag == ENTRY_EXACT) begin
        // Mate scores come back relative to this node.
        if (v > hi) begin
          res = v - longint'(r.rd);
        end else if (v < lo) begin
          res = v + longint'(r.rd);
        end else begin
          res = v;
        end
        res = longint'(sat_word(res));
        known = 1'b1;
      end else if (flag == ENTRY_STATIC) begin
        res = v;
        known = 1'b1;
      end else if (flag == ENTRY_ALPHA && v <= longint'($signed(r.alpha))) begin
        res = longint'($signed(r.alpha));
        known = 1'b1;
      end else if (flag == ENTRY_BETA && v >= longint'($signed(r.beta))) begin
        res = longint'($signed(r.beta));
        known = 1'b1;
      end
    end
    if (known) begin
      a.known = 1'b1;
      a.score = res[31:0];
    end else if (flag == ENTRY_EXACT || flag == ENTRY_BETA) begin
      a.hint_valid = 1'b1;
      a.hint = tt_move[ix];
    end
    return a;
  endfunction

  function automatic logic [stt_pkg::IN_DATA_W-1:0] pack_request(input tt_req_t r);
    return {2'b00, r.beta, r.alpha, r.move, r.score, r.rd, r.ply, r.depth, r.key, r.slot};
  endfunction

  function automatic tt_req_t mk(input logic st, input logic [11:0] slot,
                                 input logic [63:0] key, input logic [15:0] depth,
                                 input logic [15:0] ply, input logic [9:0] rd,
                                 input logic [1:0] kind, input logic signed [31:0] score,
                                 input logic [15:0] move, input logic signed [31:0] alpha,
                                 input logic signed [31:0] beta);
    tt_req_t r;
    r.is_store = st;
    r.slot = slot;
    r.key = key;
    r.depth = depth;
    r.ply = ply;
    r.rd = rd;
    r.kind = kind;
    r.score = score;
    r.move = move;
    r.alpha = alpha;
    r.beta = beta;
    return r;
  endfunction

  // Scores: small most often, many around the mate threshold, some anywhere, some extremes.
  function automatic logic signed [31:0] pick_score();
    int unsigned sel;
    longint      t;
    logic [31:0] w;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      t = longint'($urandom_range(0, 400)) - 200;
    end else if (sel < 70) begin
      t = ms_q - mm_q + longint'($urandom_range(0, 80)) - 40;
      if ($urandom_range(0, 1) == 1) begin
        t = -t;
      end
    end else if (sel < 85) begin
      w = $urandom;
      if (w == 32'h8000_0000) begin
        w = 32'h8000_0001;
      end
      t = longint'($signed(w));
    end else begin
      case ($urandom_range(0, 4))
        0: t = SCORE_TOP;
        1: t = -SCORE_TOP;
        2: t = 0;
        3: t = -1;
        default: t = 1;
      endcase
    end
    return sat_word(t);
  endfunction

  function automatic tt_req_t make_req();
    tt_req_t     r;
    int unsigned sel;
    r.is_store = ($urandom_range(0, 99) < 45) ? REQ_STORE : REQ_LOOKUP;
    r.slot = ($urandom_range(0, 99) < 80) ? 12'(hot_base + $urandom_range(0, 7))
                                          : 12'($urandom);
    r.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)]
                                         : {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    r.depth = (sel < 60) ? 16'($urandom_range(0, 12)) :
              (sel < 75) ? 16'($urandom) : (sel < 85) ? 16'hFFFF : 16'h0000;
    sel = $urandom_range(0, 99);
    r.ply = (sel < 60) ? 16'($urandom_range(0, 30)) :
            (sel < 80) ? 16'($urandom) : (sel < 90) ? 16'hFFFF : 16'h0000;
    sel = $urandom_range(0, 99);
    r.rd = (sel < 50) ? 10'($urandom_range(0, 20)) :
           (sel < 90) ? 10'($urandom) : 10'h3FF;
    r.kind = 2'($urandom);
    r.score = pick_score();
    r.move = 16'($urandom);
    r.alpha = pick_score();
    r.beta = pick_score();
    return r;
  endfunction

  task automatic queue_request(input tt_req_t r);
    request_q.push_back(r);
    issued++;
  endtask

  // Mostly a store followed by probes of the same position, the rest loose requests.
  task automatic add_traffic(input int n);
    tt_req_t s;
    tt_req_t l;
    int      cnt;
    int      probes;
    cnt = 0;
    while (cnt < n) begin
      s = make_req();
      if ($urandom_range(0, 99) < 65) begin
        s.is_store = REQ_STORE;
        queue_request(s);
        cnt++;
        probes = $urandom_range(1, 3);
        repeat (probes) begin
          l = make_req();
          l.is_store = REQ_LOOKUP;
          l.slot = s.slot;
          if ($urandom_range(0, 9) != 0) begin
            l.key = s.key;
          end
          case ($urandom_range(0, 3))
            0, 1: l.depth = 16'($urandom_range(0, int'(s.depth)));
            2: l.depth = s.depth + 16'd1;
            default: ;
          endcase
          if ($urandom_range(0, 1) == 1) begin
            l.alpha = sat_word(longint'($signed(s.score)) + longint'($urandom_range(0, 2)) - 1);
            l.beta = sat_word(longint'($signed(s.score)) + longint'($urandom_range(0, 2)) - 1);
          end
          queue_request(l);
          cnt++;
        end
      end else begin
        queue_request(s);
        cnt++;
      end
    end
  endtask

  // Wait until every issued transaction has its result, then let the pipeline settle.
  task automatic wait_quiet();
    while (received < issued) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mate(input longint score_v, input longint margin_v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= stt_pkg::CFG_MATE_SCORE;
    cfg_wdata <= stt_pkg::CFG_W'(score_v);
    ms_q = score_v;
    @(posedge clk);
    cfg_index <= stt_pkg::CFG_MATE_MARGIN;
    cfg_wdata <= stt_pkg::CFG_W'(margin_v);
    mm_q = margin_v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps when the phase allows them.
  tt_req_t cur_req;
  int      burst_left = 0;
  int      gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        answer_q.push_back(resolve_request(cur_req));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_req = request_q.pop_front();
          in_tdata <= pack_request(cur_req);
          in_tuser <= {cur_req.kind, cur_req.is_store};
          in_tvalid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            if (tx_gap_max > 0) begin
              gap_left = $urandom_range(1, tx_gap_max);
            end
          end
        end
      end
    end
  end

  // Receiver: stall pattern per phase, plus a long hold-off on request.
  int rx_cnt = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cnt++;
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_RANDOM: out_tready <= ($urandom_range(0, 9) < 7);
          RX_PATTERN: out_tready <= ((rx_cnt % 7) < 4);
          RX_SPARSE: out_tready <= ($urandom_range(0, 9) < 2);
          default: out_tready <= 1'b1;
        endcase
      end
    end
  end

  // Result checker: each result transaction against the oldest prediction.
  tt_ans_t got;
  tt_ans_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      received++;
      got.known = out_tuser[0];
      got.hint_valid = out_tuser[1];
      got.exact = out_tuser[2];
      got.stored = out_tuser[3];
      got.score = out_tdata[31:0];
      got.hint = out_tdata[47:32];
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: unexpected result transaction at cycle %0d", cycles);
        end
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: result %0d mismatch", received);
            $display("  expected known=%0b score=%0d hint_valid=%0b hint=%h exact=%0b stored=%0b",
                     want.known, want.score, want.hint_valid, want.hint, want.exact,
                     want.stored);
            $display("  actual   known=%0b score=%0d hint_valid=%0b hint=%h exact=%0b stored=%0b",
                     got.known, got.score, got.hint_valid, got.hint, got.exact, got.stored);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus sequence.
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] S_TOP = 32'sd2147483647;
  localparam logic signed [31:0] S_BOT = -32'sd2147483647;

  longint phase_ms [6] = '{1, 1073741823, 100000, 0, 1, 5000};
  longint phase_mm [6] = '{1023, 0, 64, 0, 0, 1023};

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tt_key[i] = '0;
      tt_depth[i] = '0;
      tt_ply[i] = '0;
      tt_flag[i] = ENTRY_EMPTY;
      tt_score[i] = '0;
      tt_move[i] = '0;
    end
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset mate settings.
    tx_gap_max = 3;
    rx_mode = RX_RANDOM;
    // Empty slot whose cleared key equals the probe key.
    queue_request(mk(REQ_LOOKUP, 12'd0, 64'd0, 16'd0, 16'd0, 10'd0, KIND_EXACT, 0, 0, 0, 0));
    // Largest everything, mate score saturating on the way in.
    queue_request(mk(REQ_STORE, 12'hFFF, KEY_ONES, 16'hFFFF, 16'hFFFF, 10'h3FF, KIND_EXACT,
                     S_TOP, 16'hFFFF, 0, 0));
    queue_request(mk(REQ_LOOKUP, 12'hFFF, KEY_ONES, 16'hFFFF, 16'd0, 10'h3FF, KIND_EXACT,
                     0, 0, S_BOT, S_TOP));
    queue_request(mk(REQ_LOOKUP, 12'hFFF, KEY_ONES, 16'd0, 16'd0, 10'd0, KIND_EXACT,
                     0, 0, 0, 0));
    queue_request(mk(REQ_LOOKUP, 12'hFFF, 64'd1, 16'd0, 16'd0, 10'd0, KIND_EXACT, 0, 0, 0, 0));
    // A non-exact store never replaces an exact entry.
    queue_request(mk(REQ_STORE, 12'hFFF, 64'd7, 16'd0, 16'd0, 10'd0, KIND_STATIC,
                     5, 16'h1234, 0, 0));
    // Negative mate score saturating, then read back shifted.
    queue_request(mk(REQ_STORE, 12'd1, 64'hA5A5_0000_5A5A_FFFF, 16'd0, 16'd0, 10'h3FF,
                     KIND_EXACT, S_BOT, 16'h00F0, 0, 0));
    queue_request(mk(REQ_LOOKUP, 12'd1, 64'hA5A5_0000_5A5A_FFFF, 16'd0, 16'd0, 10'd5,
                     KIND_EXACT, 0, 0, 0, 0));
    // Too shallow: the exact entry only offers its move.
    queue_request(mk(REQ_LOOKUP, 12'd1, 64'hA5A5_0000_5A5A_FFFF, 16'd1, 16'd0, 10'd5,
                     KIND_EXACT, 0, 0, 0, 0));
    // Static entry beyond the threshold comes back unshifted.
    queue_request(mk(REQ_STORE, 12'd2, 64'd22, 16'd5, 16'd5, 10'd10, KIND_STATIC,
                     99950, 16'h0202, 0, 0));
    queue_request(mk(REQ_LOOKUP, 12'd2, 64'd22, 16'd5, 16'd0, 10'd10, KIND_EXACT, 0, 0, 0, 0));
    // Depth preference: shallower work is dropped, equal work replaces.
    queue_request(mk(REQ_STORE, 12'd2, 64'd22, 16'd3, 16'd6, 10'd0, KIND_ALPHA,
                     50, 16'h0303, 0, 0));
    queue_request(mk(REQ_STORE, 12'd2, 64'd22, 16'd5, 16'd5, 10'd0, KIND_ALPHA,
                     50, 16'h0404, 0, 0));
    // Fail-low bound: alpha when the stored score is at or under it.
    queue_request(mk(REQ_LOOKUP, 12'd2, 64'd22, 16'd5, 16'd0, 10'd0, KIND_EXACT,
                     0, 0, 50, 60));
    queue_request(mk(REQ_LOOKUP, 12'd2, 64'd22, 16'd5, 16'd0, 10'd0, KIND_EXACT,
                     0, 0, 49, 60));
    // Fail-high bound: beta when the stored score is at or over it, else a hint.
    queue_request(mk(REQ_STORE, 12'd3, 64'd33, 16'd2, 16'd0, 10'd0, KIND_BETA,
                     -100, 16'h0505, 0, 0));
    queue_request(mk(REQ_LOOKUP, 12'd3, 64'd33, 16'd2, 16'd0, 10'd0, KIND_EXACT,
                     0, 0, -200, -100));
    queue_request(mk(REQ_LOOKUP, 12'd3, 64'd33, 16'd2, 16'd0, 10'd0, KIND_EXACT,
                     0, 0, -200, -99));
    queue_request(mk(REQ_LOOKUP, 12'd3, 64'd33, 16'd3, 16'd0, 10'd0, KIND_EXACT,
                     0, 0, -200, -200));
    // Exact store over a bound entry, then a score below the negative threshold.
    queue_request(mk(REQ_STORE, 12'd2, 64'd22, 16'hFFFF, 16'hFFFF, 10'd0, KIND_EXACT,
                     0, 16'h0606, 0, 0));
    queue_request(mk(REQ_STORE, 12'd5, 64'd55, 16'd1, 16'd1, 10'd20, KIND_EXACT,
                     -99950, 16'h0707, 0, 0));
    queue_request(mk(REQ_LOOKUP, 12'd5, 64'd55, 16'd1, 16'd0, 10'd20, KIND_EXACT,
                     0, 0, 0, 0));
    wait_quiet();

    // Random phases, each under its own mate settings and traffic shape.
    for (int p = 0; p < 6; p++) begin
      if (p == 3) begin
        phase_ms[p] = $urandom_range(1, 1073741823);
        phase_mm[p] = $urandom_range(0, 1023);
      end
      write_mate(phase_ms[p], phase_mm[p]);
      hot_base = (p == 0) ? 12'hFFC : 12'($urandom);
      key_pool[0] = 64'd0;
      key_pool[1] = KEY_ONES;
      for (int k = 2; k < 8; k++) begin
        key_pool[k] = {$urandom, $urandom};
      end
      tx_gap_max = (p % 3 == 0) ? 0 : 4 * p;
      rx_mode = p % 4;
      if (p == 2) begin
        // Long receiver hold-off while the sender keeps pushing.
        tx_gap_max = 0;
        rx_mode = RX_OPEN;
        hold_tag++;
      end
      if (p == 4) begin
        // Sender drains everything halfway through.
        add_traffic(85);
        while (received < issued) begin
          @(posedge clk);
        end
        add_traffic(90);
      end else begin
        add_traffic(175);
      end
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (answer_q.size() != 0) begin
      errors += answer_q.size();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
